// ===== hw/rtl/integer_to_ascii_formatter_macros.svh =====
// assertion macros used by the checker file itaf_checker.sv
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// a implies b in the same cycle
`define ITAF_ASSERT_NOW(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define ITAF_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== hw/rtl/itaf_pkg.sv =====
// types and constants of the integer to ascii formatter
// no dependencies
`default_nettype none

package itaf_pkg;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_HEX = 2'd1;
	localparam logic [1:0] BASE_OCT = 2'd2;
	localparam logic [1:0] BASE_BIN = 2'd3;

	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_SPACE = 2'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [6:0] MAX_TEXT = 7'd64;

	typedef struct packed {
		logic [63:0] magnitude;
		logic        negative;
		logic [1:0]  base_sel;
		logic [5:0]  precision;
		logic [6:0]  field_width;
		logic        left_align;
		logic        zero_pad;
		logic [1:0]  sign_mode;
		logic        alt_form;
		logic        upper_case;
		logic        precision_given;
		logic        pointer_form;
	} itaf_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_char;
		logic       empty_text;
	} itaf_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// integer to ascii formatter, top level
// depends on itaf_pkg
//
// usage:
//   item channel (item_valid, item_stall, item) takes one number with its
//   printf flags; text channel (text_valid, text_stall, text) returns the
//   formatted characters one word each, last_char set on the final one.
//   when nothing is printed a single word with empty_text set is returned.
// operation:
//   decimal values other than zero run a binary to bcd conversion first;
//   then the digits, the padding zeros and the prefix and sign slots are
//   written to the buffer, the first read is primed and the output words
//   are sent, each one held while text_stall is high.
//   one item is in work at a time; item_stall is high until the last word
//   has been loaded into the output register.
// reset clears the control state; the text register holds its word while
// text_stall is high and the formatter waits.
`default_nettype none

module integer_to_ascii_formatter #(
	parameter int DIGIT_BUFFER_SIZE = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  itaf_pkg::itaf_in_t   item,
	output logic                 text_valid,
	input  wire                  text_stall,
	output itaf_pkg::itaf_out_t  text
);
	import itaf_pkg::*;

	localparam int AW = (DIGIT_BUFFER_SIZE > 1) ? $clog2(DIGIT_BUFFER_SIZE) : 1;
	localparam logic [6:0] SZ = 7'(DIGIT_BUFFER_SIZE);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DABBLE = 4'd1;
	localparam logic [3:0] ST_DIGIT  = 4'd2;
	localparam logic [3:0] ST_PAD    = 4'd3;
	localparam logic [3:0] ST_PFX    = 4'd4;
	localparam logic [3:0] ST_PUSH   = 4'd5;
	localparam logic [3:0] ST_PRIME  = 4'd6;
	localparam logic [3:0] ST_EMIT   = 4'd7;

	logic [3:0]  state_q;
	logic [79:0] sr_q;
	logic [63:0] mag_q;
	logic [5:0]  cnt_q;
	logic [1:0]  base_q;
	logic        upper_q, neg_q, ptr_q, pgiven_q, left_q, zpad_q, alt_q, plus_q, space_q;
	logic [5:0]  prec_q;
	logic [6:0]  width_q;
	logic [6:0]  len_q;
	logic [6:0]  unpad_q;
	logic [2:0]  pv_q;
	logic [7:0]  pc0_q, pc1_q, pc2_q;
	logic [6:0]  lead_q, total_q, pos_q;
	logic [7:0]  rd_q;
	logic [7:0]  buf_q [DIGIT_BUFFER_SIZE];

	logic        buf_we;
	logic [AW-1:0] buf_wa, buf_ra;
	logic [7:0]  buf_wd;

	// accept-time normalization
	logic [6:0] width_c;
	logic       zpad_c, sign_c;
	always_comb begin
		width_c = (item.field_width > MAX_TEXT) ? MAX_TEXT : item.field_width;
		zpad_c  = item.zero_pad & ~item.precision_given;
		sign_c  = item.negative | (item.sign_mode == SIGN_PLUS) |
			(item.sign_mode == SIGN_SPACE);
		if (!item.left_align && width_c != 7'd0 && zpad_c && sign_c)
			width_c = width_c - 7'd1;
	end

	// double dabble adjust
	logic [79:0] adj_c;
	always_comb begin
		for (int i = 0; i < 20; i++)
			adj_c[4*i +: 4] = (sr_q[4*i +: 4] >= 4'd5) ? sr_q[4*i +: 4] + 4'd3
				: sr_q[4*i +: 4];
	end

	// digit step
	logic [3:0]  dig_c;
	logic [79:0] sr_next_c;
	logic [7:0]  dch_c;
	always_comb begin
		unique case (base_q)
			BASE_DEC, BASE_HEX: begin
				dig_c = sr_q[3:0];
				sr_next_c = sr_q >> 4;
			end
			BASE_OCT: begin
				dig_c = {1'b0, sr_q[2:0]};
				sr_next_c = sr_q >> 3;
			end
			default: begin
				dig_c = {3'b0, sr_q[0]};
				sr_next_c = sr_q >> 1;
			end
		endcase
		if (dig_c < 4'd10)
			dch_c = CH_ZERO + {4'b0, dig_c};
		else
			dch_c = (upper_q ? CH_UA : CH_LA) + {4'b0, dig_c} - 8'd10;
	end

	// padding and prefix
	logic       pad_c, alt_eff_c;
	logic [6:0] len_adj_c;
	always_comb begin
		pad_c = ((!left_q && zpad_q && len_q < width_q) || (len_q < {1'b0, prec_q}))
			&& len_q < SZ;
		alt_eff_c = alt_q & ~(base_q == BASE_OCT && len_q > unpad_q);
		len_adj_c = len_q;
		if (!pgiven_q && len_q != 7'd0 && (len_q == {1'b0, prec_q} || len_q == width_q))
		begin
			if (unpad_q < len_adj_c)
				len_adj_c = len_adj_c - 7'd1;
			if (len_adj_c != 7'd0 && (base_q == BASE_HEX || base_q == BASE_BIN) &&
				unpad_q < len_adj_c)
				len_adj_c = len_adj_c - 7'd1;
		end
	end

	// emit bookkeeping
	logic [6:0] lead_c, total_c, pos_nx_c, idx_c;
	logic       slot_free_c, load_c, last_c, emit_empty_c;
	logic [7:0] ch_c;
	always_comb begin
		lead_c  = (!left_q && !zpad_q && width_q > len_q) ? width_q - len_q : 7'd0;
		total_c = (zpad_q && !left_q) ? len_q : ((width_q > len_q) ? width_q : len_q);
		slot_free_c = !text_valid || !text_stall;
		load_c = (state_q == ST_EMIT) && slot_free_c;
		pos_nx_c = load_c ? pos_q + 7'd1 : pos_q;
		if (state_q == ST_PRIME)
			idx_c = lead_c + len_q - 7'd1;
		else
			idx_c = lead_q + len_q - 7'd1 - pos_nx_c;
		emit_empty_c = (total_q == 7'd0);
		last_c = emit_empty_c || (pos_q + 7'd1 == total_q);
		if (emit_empty_c)
			ch_c = CH_NUL;
		else if (pos_q < lead_q || pos_q >= lead_q + len_q)
			ch_c = CH_SPACE;
		else
			ch_c = rd_q;
	end

	// buffer write port
	always_comb begin
		buf_we = 1'b0;
		buf_wa = len_q[AW-1:0];
		buf_wd = CH_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				buf_we = item_valid && item.magnitude == 64'd0 && !item.precision_given;
				buf_wa = '0;
			end
			ST_DIGIT: begin
				buf_we = 1'b1;
				buf_wd = dch_c;
			end
			ST_PAD: buf_we = pad_c;
			ST_PUSH: begin
				buf_we = (pv_q != 3'b000) && len_q < SZ;
				buf_wd = pv_q[0] ? pc0_q : (pv_q[1] ? pc1_q : pc2_q);
			end
			default: buf_we = 1'b0;
		endcase
		buf_ra = idx_c[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (buf_we)
			buf_q[buf_wa] <= buf_wd;
		rd_q <= buf_q[buf_ra];
	end

	assign item_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			text_valid <= 1'b0;
		end else begin
			if (text_valid && !text_stall)
				text_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (item_valid) begin
					if (item.magnitude == 64'd0)
						state_q <= ST_PAD;
					else if (item.base_sel == BASE_DEC)
						state_q <= ST_DABBLE;
					else
						state_q <= ST_DIGIT;
				end
				ST_DABBLE: if (cnt_q == 6'd0) state_q <= ST_DIGIT;
				ST_DIGIT: if (sr_next_c == 80'd0 || len_q + 7'd1 == SZ) state_q <= ST_PAD;
				ST_PAD: if (!pad_c) state_q <= ST_PFX;
				ST_PFX: state_q <= ST_PUSH;
				ST_PUSH: if (pv_q == 3'b000) state_q <= ST_PRIME;
				ST_PRIME: state_q <= ST_EMIT;
				ST_EMIT: if (load_c) begin
					text_valid <= 1'b1;
					if (last_c)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (item_valid) begin
				base_q   <= item.base_sel;
				upper_q  <= item.upper_case;
				neg_q    <= item.negative;
				ptr_q    <= item.pointer_form;
				pgiven_q <= item.precision_given;
				left_q   <= item.left_align;
				zpad_q   <= zpad_c;
				plus_q   <= item.sign_mode == SIGN_PLUS;
				space_q  <= item.sign_mode == SIGN_SPACE;
				prec_q   <= item.precision;
				width_q  <= width_c;
				mag_q    <= item.magnitude;
				cnt_q    <= 6'd63;
				alt_q    <= item.alt_form && item.base_sel != BASE_DEC;
				if (item.magnitude == 64'd0) begin
					if (!item.precision_given) begin
						len_q   <= 7'd1;
						unpad_q <= 7'd1;
						alt_q   <= 1'b0;
					end else begin
						len_q   <= 7'd0;
						unpad_q <= 7'd0;
						if (item.base_sel == BASE_HEX)
							alt_q <= 1'b0;
					end
				end else begin
					len_q <= 7'd0;
					sr_q  <= (item.base_sel == BASE_DEC) ? 80'd0 : {16'd0, item.magnitude};
				end
			end
			ST_DABBLE: begin
				sr_q  <= {adj_c[78:0], mag_q[63]};
				mag_q <= mag_q << 1;
				cnt_q <= cnt_q - 6'd1;
			end
			ST_DIGIT: begin
				sr_q    <= sr_next_c;
				len_q   <= len_q + 7'd1;
				unpad_q <= len_q + 7'd1;
			end
			ST_PAD: if (pad_c) len_q <= len_q + 7'd1;
			ST_PFX: begin
				pv_q[0] <= (alt_eff_c || ptr_q) && (base_q == BASE_HEX || base_q == BASE_BIN);
				pc0_q   <= (base_q == BASE_HEX) ? (upper_q ? CH_UX : CH_LX) : CH_LB;
				pv_q[1] <= alt_eff_c || ptr_q;
				pc1_q   <= CH_ZERO;
				pv_q[2] <= neg_q || plus_q || space_q;
				pc2_q   <= neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_SPACE);
				if (alt_eff_c || ptr_q)
					len_q <= len_adj_c;
			end
			ST_PUSH: begin
				if (pv_q[0])
					pv_q[0] <= 1'b0;
				else if (pv_q[1])
					pv_q[1] <= 1'b0;
				else
					pv_q[2] <= 1'b0;
				if (pv_q != 3'b000 && len_q < SZ)
					len_q <= len_q + 7'd1;
			end
			ST_PRIME: begin
				lead_q  <= lead_c;
				total_q <= total_c;
				pos_q   <= 7'd0;
			end
			ST_EMIT: if (load_c) begin
				pos_q           <= pos_nx_c;
				text.out_char   <= ch_c;
				text.last_char  <= last_c;
				text.empty_text <= emit_empty_c;
			end
			default: pos_q <= pos_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/itaf_checker.sv =====
// port-level checks for the integer to ascii formatter, with its bind
// depends on itaf_pkg and integer_to_ascii_formatter_macros.svh
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"

module itaf_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  item_valid,
	input wire                  item_stall,
	input wire                  text_valid,
	input wire                  text_stall,
	input itaf_pkg::itaf_out_t  text
);
	import itaf_pkg::*;

	`ITAF_ASSERT_NEXT(a_hold, text_valid && text_stall, text_valid && $stable(text), "stalled word changed")
	`ITAF_ASSERT_NOW(a_empty_last, text_valid && text.empty_text, text.last_char, "empty word not last")
	`ITAF_ASSERT_NOW(a_empty_nul, text_valid && text.empty_text, text.out_char == CH_NUL, "empty word has char")
	`ITAF_ASSERT_NEXT(a_busy, item_valid && !item_stall, item_stall, "second word taken while busy")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for integer_to_ascii_formatter
// formats random and directed numbers and compares every output word against a local formatter
// depends on itaf_pkg and the integer_to_ascii_formatter rtl
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import itaf_pkg::*;

	localparam int BUF_SIZE = 32;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 420;
	localparam int DIRECTED_ITEMS = 21;
	localparam int IN_BITS = $bits(itaf_in_t);

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	itaf_in_t item;
	logic text_valid;
	logic text_stall;
	itaf_out_t text;

	itaf_in_t pending_items[$];
	itaf_out_t expected_chars[$];
	int errors;
	int words_checked;
	int items_sent;
	int idle_cycles;
	int send_wait;
	int recv_wait;
	int send_draw;
	int recv_draw;
	bit in_taken;
	bit out_taken;

	integer_to_ascii_formatter #(.DIGIT_BUFFER_SIZE(BUF_SIZE)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text(text)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] digit_char(int d, bit upper);
		if (d < 10)
			return CH_ZERO + 8'(d);
		return (upper ? CH_UA : CH_LA) + 8'(d - 10);
	endfunction

	// computes the formatted text of one item and queues its words
	task automatic format_number(input itaf_in_t it);
		logic [7:0] digits[BUF_SIZE];
		logic [7:0] line[$];
		logic [63:0] val;
		int base, len, unpadded, width, prec, i;
		bit alt, zpad, plus, space, ptr, pgiven;
		itaf_out_t w;
		val = it.magnitude;
		case (it.base_sel)
			BASE_DEC: base = 10;
			BASE_HEX: base = 16;
			BASE_OCT: base = 8;
			default: base = 2;
		endcase
		prec = int'(it.precision);
		width = (it.field_width > MAX_TEXT) ? 64 : int'(it.field_width);
		alt = it.alt_form && base != 10;
		pgiven = it.precision_given;
		zpad = it.zero_pad && !pgiven;
		plus = it.sign_mode == SIGN_PLUS;
		space = it.sign_mode == SIGN_SPACE;
		ptr = it.pointer_form;
		len = 0;
		if (val == 64'd0) begin
			if (!pgiven) begin
				digits[len++] = CH_ZERO;
				alt = 1'b0;
			end else if (base == 16) begin
				alt = 1'b0;
			end
		end else begin
			do begin
				digits[len++] = digit_char(int'(val % 64'(base)), it.upper_case);
				val = val / 64'(base);
			end while (val != 64'd0 && len < BUF_SIZE);
		end
		unpadded = len;
		if (!it.left_align) begin
			if (width != 0 && zpad && (it.negative || plus || space))
				width--;
			while (zpad && len < width && len < BUF_SIZE)
				digits[len++] = CH_ZERO;
		end
		while (len < prec && len < BUF_SIZE)
			digits[len++] = CH_ZERO;
		if (base == 8 && len > unpadded)
			alt = 1'b0;
		if (alt || ptr) begin
			if (!pgiven && len != 0 && (len == prec || len == width)) begin
				if (unpadded < len)
					len--;
				if (len != 0 && (base == 16 || base == 2) && unpadded < len)
					len--;
			end
			if (base == 16 && len < BUF_SIZE)
				digits[len++] = it.upper_case ? CH_UX : CH_LX;
			else if (base == 2 && len < BUF_SIZE)
				digits[len++] = CH_LB;
			if (len < BUF_SIZE)
				digits[len++] = CH_ZERO;
		end
		if (len < BUF_SIZE) begin
			if (it.negative)
				digits[len++] = CH_MINUS;
			else if (plus)
				digits[len++] = CH_PLUS;
			else if (space)
				digits[len++] = CH_SPACE;
		end
		if (!it.left_align && !zpad)
			for (i = len; i < width && line.size() < 64; i++)
				line.push_back(CH_SPACE);
		i = len;
		while (i != 0 && line.size() < 64)
			line.push_back(digits[--i]);
		if (it.left_align)
			while (line.size() < width && line.size() < 64)
				line.push_back(CH_SPACE);
		if (line.size() == 0) begin
			w.out_char = CH_NUL;
			w.last_char = 1'b1;
			w.empty_text = 1'b1;
			expected_chars.push_back(w);
		end else begin
			for (i = 0; i < line.size(); i++) begin
				w.out_char = line[i];
				w.last_char = (i == line.size() - 1);
				w.empty_text = 1'b0;
				expected_chars.push_back(w);
			end
		end
	endtask

	function automatic itaf_in_t random_item();
		itaf_in_t it;
		int sel;
		it = itaf_in_t'(IN_BITS'({$urandom, $urandom, $urandom}));
		sel = $urandom_range(0, 3);
		if (sel == 0)
			it.magnitude = 64'($urandom_range(0, 300));
		else if (sel == 1)
			it.magnitude = {$urandom, $urandom} >> $urandom_range(0, 63);
		it.field_width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127))
			: 7'($urandom_range(0, 40));
		it.precision = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
		return it;
	endfunction

	function automatic itaf_in_t directed_item(int k);
		itaf_in_t it;
		it = '0;
		it.base_sel = 2'(k % 4);
		case (k)
			0: it.magnitude = '1;
			1: begin it.magnitude = '1; it.upper_case = 1'b1; it.alt_form = 1'b1; end
			2: begin it.magnitude = '1; it.alt_form = 1'b1; end
			3: begin it.magnitude = '1; it.pointer_form = 1'b1; end
			4: begin it.negative = 1'b1; it.field_width = 7'd127; it.zero_pad = 1'b1; end
			5: begin it.precision_given = 1'b1; it.alt_form = 1'b1; end
			6: begin it.precision_given = 1'b1; it.alt_form = 1'b1; it.sign_mode = 2'd3; end
			7: begin it.magnitude = 64'd5; it.alt_form = 1'b1; it.precision = 6'd6;
				it.field_width = 7'd6; end
			8: begin it.magnitude = 64'd255; it.alt_form = 1'b1; it.field_width = 7'd8;
				it.zero_pad = 1'b1; end
			9: begin it.magnitude = 64'd26; it.alt_form = 1'b1; it.precision = 6'd8; end
			10: begin it.magnitude = 64'd9; it.alt_form = 1'b1; it.zero_pad = 1'b1;
				it.field_width = 7'd5; end
			11: begin it.magnitude = 64'd3; it.pointer_form = 1'b1; it.field_width = 7'd10; end
			12: begin it.magnitude = 64'd77; it.sign_mode = SIGN_PLUS; it.zero_pad = 1'b1;
				it.field_width = 7'd9; end
			13: begin it.magnitude = 64'd77; it.sign_mode = SIGN_SPACE; it.left_align = 1'b1;
				it.field_width = 7'd64; end
			14: begin it.magnitude = 64'd1; it.precision = 6'd63; it.sign_mode = SIGN_PLUS; end
			15: begin it.magnitude = 64'd12; it.precision_given = 1'b1; it.zero_pad = 1'b1;
				it.field_width = 7'd8; it.precision = 6'd4; end
			16: begin it.magnitude = 64'd42; it.alt_form = 1'b1; it.field_width = 7'd64;
				it.zero_pad = 1'b1; it.negative = 1'b1; end
			17: begin it.magnitude = 64'd0; it.pointer_form = 1'b1; it.precision_given = 1'b1; end
			18: begin it.magnitude = 64'h8000_0000_0000_0000; it.negative = 1'b1; end
			19: begin it.magnitude = '1; it.left_align = 1'b1; it.field_width = 7'd100; end
			default: begin it.magnitude = 64'd0; it.precision_given = 1'b1; end
		endcase
		return it;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				send_draw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
				if (send_draw == 0 && pending_items.size() != 0) begin
					item <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
					send_wait <= (send_draw != 0) ? send_draw - 1 : 0;
				end
			end else if (!item_valid && pending_items.size() != 0) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
				end else begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end
			end
			if (out_taken) begin
				recv_draw = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
				text_stall <= (recv_draw != 0);
				recv_wait <= (recv_draw != 0) ? recv_draw - 1 : 0;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				text_stall <= 1'b1;
			end else begin
				text_stall <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= item_valid && !item_stall;
			out_taken <= text_valid && !text_stall;
			idle_cycles <= ((item_valid && !item_stall) || (text_valid && !text_stall)) ? 0
				: idle_cycles + 1;
			if (item_valid && !item_stall) begin
				format_number(item);
				items_sent <= items_sent + 1;
			end
			if (text_valid && !text_stall) begin
				words_checked <= words_checked + 1;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected word char=%h last=%b empty=%b", $time,
						text.out_char, text.last_char, text.empty_text);
					errors <= errors + 1;
				end else begin
					itaf_out_t e;
					e = expected_chars.pop_front();
					if (e.out_char !== text.out_char || e.last_char !== text.last_char ||
						e.empty_text !== text.empty_text) begin
						$display("%0t: mismatch expected char=%h last=%b empty=%b",
							$time, e.out_char, e.last_char, e.empty_text);
						$display("%0t:          actual   char=%h last=%b empty=%b",
							$time, text.out_char, text.last_char, text.empty_text);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d words outstanding", expected_chars.size());
			$display("FAIL integer_to_ascii_formatter");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		text_stall = 1'b0;
		errors = 0;
		words_checked = 0;
		items_sent = 0;
		idle_cycles = 0;
		send_wait = 0;
		recv_wait = 0;
		send_draw = 0;
		recv_draw = 0;
		in_taken = 1'b0;
		out_taken = 1'b0;
		for (int k = 0; k < DIRECTED_ITEMS; k++)
			pending_items.push_back(directed_item(k));
		for (int k = 0; k < RANDOM_ITEMS; k++)
			pending_items.push_back(random_item());
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (items_sent == DIRECTED_ITEMS + RANDOM_ITEMS);
		wait (expected_chars.size() == 0);
		repeat (200) @(posedge clk);
		$display("formatted %0d numbers in all bases, %0d output words checked",
			items_sent, words_checked);
		if (errors == 0 && expected_chars.size() == 0)
			$display("PASS integer_to_ascii_formatter");
		else
			$display("FAIL integer_to_ascii_formatter");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/itaf_pkg.sv
hw/rtl/integer_to_ascii_formatter.sv
hw/rtl/itaf_checker.sv
tb/tb_top.sv
